// ----- hw/rtl/tea_pkg.sv -----
// Package: shared constants, types and round-sum function for the TEA block decryptor.
`timescale 1ns / 1ps
package tea_pkg;

	localparam int unsigned TeaRounds   = 32;
	localparam int unsigned TeaHalves   = 2 * TeaRounds;
	localparam logic [31:0] TeaSumStart = 32'hC6EF3720;
	localparam logic [31:0] TeaDelta    = 32'h9E3779B9;

	localparam int unsigned CfgIdxW = 8;
	localparam logic [CfgIdxW-1:0] CfgKey0 = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CfgKey1 = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] CfgKey2 = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] CfgKey3 = CfgIdxW'(3);

	localparam logic [31:0] KeyReset0 = 32'd1;
	localparam logic [31:0] KeyReset1 = 32'd2;
	localparam logic [31:0] KeyReset2 = 32'd3;
	localparam logic [31:0] KeyReset3 = 32'd4;

	typedef struct packed {
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
	} key_t;

	// src feeds the mix, dst takes the subtraction; the two swap every half round.
	typedef struct packed {
		logic        valid;
		logic [31:0] src;
		logic [31:0] dst;
		logic        last;
	} half_t;

	// Sum used by round r (same value for both halves of the round).
	function automatic logic [31:0] round_sum(input int unsigned r);
		logic [31:0] step;
		step = 32'(r) * TeaDelta;
		return TeaSumStart - step;
	endfunction

endpackage

// ----- hw/rtl/tea_key_regs.sv -----
// Key register file: four 32-bit key words written over the configuration channel.
`timescale 1ns / 1ps
module tea_key_regs
	import tea_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data,
	output key_t               key
);

	key_t key_q;

	assign cfg_ready = 1'b1;
	assign key       = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q.w0 <= KeyReset0;
			key_q.w1 <= KeyReset1;
			key_q.w2 <= KeyReset2;
			key_q.w3 <= KeyReset3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgKey0: key_q.w0 <= cfg_data;
				CfgKey1: key_q.w1 <= cfg_data;
				CfgKey2: key_q.w2 <= cfg_data;
				CfgKey3: key_q.w3 <= cfg_data;
				default: ; // drop writes beyond the key words
			endcase
		end
	end

endmodule

// ----- hw/rtl/tea_half_round.sv -----
// One pipeline stage: half of a TEA decryption round, dst -= mix(src), then swap.
`timescale 1ns / 1ps
module tea_half_round
	import tea_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [31:0] sum,
	input  logic [31:0] key_l,
	input  logic [31:0] key_r,
	input  half_t       in_word,
	output half_t       out_word
);

	logic        valid_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;
	logic        last_s1;
	logic [31:0] mix;
	logic [31:0] dst_new;

	assign mix = ((in_word.src << 4) + key_l) ^ (in_word.src + sum)
		^ ((in_word.src >> 5) + key_r);
	assign dst_new = in_word.dst - mix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_word.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			src_s1  <= dst_new;
			dst_s1  <= in_word.src;
			last_s1 <= in_word.last;
		end
	end

	assign out_word = '{valid: valid_s1, src: src_s1, dst: dst_s1, last: last_s1};

endmodule

// ----- hw/rtl/tea_block_decrypt.sv -----
// Top level: 64-stage pipelined TEA block decryptor with key configuration port.
`timescale 1ns / 1ps
// Decrypts one 64-bit TEA block per word: cipher_first/cipher_second are the two
// little-endian packed ciphertext words, plain_first/plain_second the plaintext,
// and last_in_message rides along to last_out untouched. Each of the 32 rounds
// is split into two half-round stages, and one word can enter every cycle while
// the pipeline advances. The whole pipeline moves as one: it advances whenever
// the final stage (which is also the output register) is empty or being taken,
// and holds otherwise, so in_ready follows out_ready combinationally through
// that one condition. The key words reset to 1, 2, 3 and 4 and are written at
// indices 0 to 3 of the configuration channel; the stages read them live, so
// change the key only with the pipeline empty. Writes to other indices are
// dropped, and cfg_ready is always high.
module tea_block_decrypt
	import tea_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        cipher_first,
	input  logic [31:0]        cipher_second,
	input  logic               last_in_message,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        plain_first,
	output logic [31:0]        plain_second,
	output logic               last_out,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data
);

	key_t  key;
	half_t pipe [0:TeaHalves];
	logic  advance;

	tea_key_regs u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	// Advance the whole pipeline unless the output word is stuck.
	assign advance  = !pipe[TeaHalves].valid || out_ready;
	assign in_ready = advance;

	// Stage 0 input: v0 is the mixed word first, v1 takes the subtraction.
	assign pipe[0].valid = in_valid;
	assign pipe[0].src   = cipher_first;
	assign pipe[0].dst   = cipher_second;
	assign pipe[0].last  = last_in_message;

	// Even halves update v1 with key words 2 and 3, odd halves update v0 with
	// key words 0 and 1. Since src and dst swap at each stage, after an even
	// number of halves src is v0 again.
	for (genvar h = 0; h < TeaHalves; h++) begin : g_half
		localparam logic [31:0] HalfSum = round_sum(h / 2);

		tea_half_round u_half (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.sum      (HalfSum),
			.key_l    ((h % 2 == 0) ? key.w2 : key.w0),
			.key_r    ((h % 2 == 0) ? key.w3 : key.w1),
			.in_word  (pipe[h]),
			.out_word (pipe[h+1])
		);
	end

	// The last stage register doubles as the output register.
	assign out_valid    = pipe[TeaHalves].valid;
	assign plain_first  = pipe[TeaHalves].src;
	assign plain_second = pipe[TeaHalves].dst;
	assign last_out     = pipe[TeaHalves].last;

endmodule
